>>> src/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, constants and helpers of the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

	localparam int MEM_WORDS = 4096;
	localparam int MEM_AW    = $clog2(MEM_WORDS);
	localparam int IDX_W     = (MEM_AW > 12) ? MEM_AW : 12;

	localparam logic [51:0] FRAME_MASK  = 52'hF_FFFF_FFFF_F000;
	localparam int          PRESENT_BIT = 0;
	localparam int          WRITE_BIT   = 1;
	localparam int          FIFO_DEPTH  = 2;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_XLATE = 1'b1;

	localparam logic [1:0] LVL_TOP  = 2'd0;
	localparam logic [1:0] LVL_L3   = 2'd1;
	localparam logic [1:0] LVL_L2   = 2'd2;
	localparam logic [1:0] LVL_LEAF = 2'd3;

	typedef struct packed {
		logic              req;
		logic [MEM_AW-1:0] widx;
		logic [63:0]       data;
		logic [47:0]       va;
	} item_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	// 9-bit table index for a walk level
	function automatic logic [8:0] va_index(input logic [47:0] va, input logic [1:0] lvl);
		logic [8:0] idx;
		case (lvl)
			LVL_TOP: idx = va[47:39];
			LVL_L3:  idx = va[38:30];
			LVL_L2:  idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

	// word address of entry idx in the table at byte address tbl, wrapped
	function automatic logic [MEM_AW-1:0] word_addr(input logic [51:0] tbl,
			input logic [8:0] idx);
		return tbl[3 +: MEM_AW] + MEM_AW'(idx);
	endfunction

	function automatic logic [51:0] frame_of(input logic [63:0] entry);
		return entry[51:0] & FRAME_MASK;
	endfunction

endpackage

>>> src/ptw_front.sv
// ----------------------------------------------------------------------------
// ptw_front
// Accepts request transfers, classifies them and queues them for the walker.
// ----------------------------------------------------------------------------
module ptw_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 req_type,
	input  logic [11:0]          mem_index,
	input  logic [63:0]          mem_data,
	input  logic [47:0]          virt_addr,
	output logic                 q_valid,
	output ptw_pkg::item_t       q_item,
	input  logic                 q_pop
);

	localparam int PTR_W = $clog2(ptw_pkg::FIFO_DEPTH);
	localparam int CNT_W = $clog2(ptw_pkg::FIFO_DEPTH + 1);

	ptw_pkg::item_t               slot_q [ptw_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0]             wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]             count_q;
	logic [ptw_pkg::IDX_W-1:0]    idx_ext;
	ptw_pkg::item_t               item;
	logic                         push, pop;

	always_comb begin
		idx_ext   = ptw_pkg::IDX_W'(mem_index);
		item.req  = (req_type == ptw_pkg::REQ_XLATE) ? ptw_pkg::REQ_XLATE : ptw_pkg::REQ_WRITE;
		item.widx = idx_ext[ptw_pkg::MEM_AW-1:0];
		item.data = mem_data;
		item.va   = virt_addr;
	end

	assign in_ready = (count_q != CNT_W'(ptw_pkg::FIFO_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(ptw_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(ptw_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/ptw_back.sv
// ----------------------------------------------------------------------------
// ptw_back
// Table memory, walk sequencer and result register.
// ----------------------------------------------------------------------------
module ptw_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  ptw_pkg::item_t       q_item,
	output logic                 q_pop,
	input  logic                 root_we,
	input  logic [51:0]          root_wdata,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [51:0]          phys_addr,
	output logic                 present,
	output logic                 writable,
	output logic                 leaf_reached
);

	logic [63:0]                 mem [ptw_pkg::MEM_WORDS];
	logic [63:0]                 rdata_q;
	ptw_pkg::state_t             state_q, state_d;
	logic [1:0]                  lvl_q;
	logic [47:0]                 va_q;
	logic [51:0]                 root_q;
	logic                        out_valid_q;
	logic [51:0]                 phys_q;
	logic                        present_q, writable_q, leaf_q;

	logic                        mem_we, mem_re, start_walk, step_walk, load_out;
	logic [ptw_pkg::MEM_AW-1:0]  mem_raddr;
	logic                        walk_more, slot_free, is_leaf;
	logic                        res_present, res_writable;
	logic [51:0]                 res_phys;

	assign is_leaf      = (lvl_q == ptw_pkg::LVL_LEAF);
	assign walk_more    = !is_leaf && rdata_q[ptw_pkg::PRESENT_BIT];
	assign slot_free    = !out_valid_q || out_ready;
	assign res_present  = is_leaf && rdata_q[ptw_pkg::PRESENT_BIT];
	assign res_writable = is_leaf && rdata_q[ptw_pkg::WRITE_BIT];
	assign res_phys     = res_present ?
		(ptw_pkg::frame_of(rdata_q) | {40'b0, va_q[11:0]}) : '0;

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_raddr  = '0;
		start_walk = 1'b0;
		step_walk  = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			ptw_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_item.req == ptw_pkg::REQ_WRITE) begin
						mem_we = 1'b1;
					end else begin
						mem_re     = 1'b1;
						start_walk = 1'b1;
						mem_raddr  = ptw_pkg::word_addr(root_q,
							ptw_pkg::va_index(q_item.va, ptw_pkg::LVL_TOP));
						state_d    = ptw_pkg::ST_WALK;
					end
				end
			end
			ptw_pkg::ST_WALK: begin
				if (walk_more) begin
					mem_re    = 1'b1;
					step_walk = 1'b1;
					mem_raddr = ptw_pkg::word_addr(ptw_pkg::frame_of(rdata_q),
						ptw_pkg::va_index(va_q, lvl_q + 2'd1));
				end else if (slot_free) begin
					load_out = 1'b1;
					state_d  = ptw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ptw_pkg::ST_IDLE;
			end
		endcase
	end

	// table memory: one access per cycle, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[q_item.widx] <= q_item.data;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (start_walk) begin
			va_q <= q_item.va;
		end
		if (load_out) begin
			phys_q     <= res_phys;
			present_q  <= res_present;
			writable_q <= res_writable;
			leaf_q     <= is_leaf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptw_pkg::ST_IDLE;
			lvl_q       <= ptw_pkg::LVL_TOP;
			root_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (root_we) begin
				root_q <= root_wdata;
			end
			if (start_walk) begin
				lvl_q <= ptw_pkg::LVL_TOP;
			end else if (step_walk) begin
				lvl_q <= lvl_q + 2'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign phys_addr    = phys_q;
	assign present      = present_q;
	assign writable     = writable_q;
	assign leaf_reached = leaf_q;

endmodule

>>> src/four_level_page_table_walk.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walk
// Page table walker over a local 4096 x 64-bit table memory.
//
// Requests arrive on in_valid/in_ready; a transfer with req_type 0 stores
// mem_data at word mem_index, one with req_type 1 translates virt_addr.
// Each translation yields one result transfer on out_valid/out_ready;
// table writes yield none. Results come out in request order.
// root_table_addr is loaded when root_table_addr_we is high; the user must
// do so only with the walker idle, which the block itself does not enforce.
// A two-entry queue sits behind the input. The walker does a table write
// while idle and stays idle. A translation reads one table level at a time
// (up to four, dependent reads on the single memory port), then loads the
// result register; a walk stops early at an entry that is not present. The
// result goes out via the read data register and the result register. If
// a result still waits with out_ready low, the finished walk holds and the
// queue keeps taking requests until full. Reset clears the queue, the walker
// and root_table_addr; the table memory is undefined until written.
// ----------------------------------------------------------------------------
module four_level_page_table_walk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [11:0] mem_index,
	input  logic [63:0] mem_data,
	input  logic [47:0] virt_addr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [51:0] phys_addr,
	output logic        present,
	output logic        writable,
	output logic        leaf_reached,
	input  logic        root_table_addr_we,
	input  logic [51:0] root_table_addr
);

	logic           q_valid, q_pop;
	ptw_pkg::item_t q_item;

	ptw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.mem_index (mem_index),
		.mem_data  (mem_data),
		.virt_addr (virt_addr),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	ptw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.root_we      (root_table_addr_we),
		.root_wdata   (root_table_addr),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.phys_addr    (phys_addr),
		.present      (present),
		.writable     (writable),
		.leaf_reached (leaf_reached)
	);

endmodule
